// ===== rtl/core/lzsstsd_pkg.sv =====
package lzsstsd_pkg;

    // Window depth default and fixed field widths
    localparam int WINDOW_DEPTH_DEF = 1024;
    localparam int DIST_W           = 10;
    localparam int LEN_W            = 6;
    localparam int LIT_W            = 7;
    localparam int COUNT_W          = 17;
    localparam int SIZE_W           = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX  = 17'h1FFFF;
    localparam logic [7:0]         TERM_CODE  = 8'h1F;
    localparam logic [LEN_W-1:0]   SHORT_BIAS = 6'd2;
    localparam logic [LEN_W-1:0]   LONG_BIAS  = 6'd3;
    localparam logic [LIT_W-1:0]   LIT_BIAS   = 7'd8;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SIZE_LO,
        ST_TOKEN,
        ST_LITERALS,
        ST_LONG_LOW,
        ST_COPY_RD,
        ST_COPY_WR
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic start;
        logic size_lo;
        logic desc_load;
        logic desc_shift;
        logic lit_load;
        logic lit_dec;
        logic long_load;
        logic match_load;
        logic match_long;
        logic copy_read;
        logic copy_write;
        logic emit_literal;
        logic emit_term;
        logic emit_derr;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic out_free;
        logic desc_empty;
        logic desc_bit;
        logic lit_last;
        logic is_term;
        logic is_packed;
        logic is_short;
        logic dist_bad_short;
        logic dist_bad_long;
        logic copy_last;
    } status_t;

endpackage

// ===== rtl/core/lzsstsd_ram.sv =====
module lzsstsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, hold when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/lzsstsd_ctrl.sv =====
module lzsstsd_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 stream_start,
    output logic                 in_ready,
    input  lzsstsd_pkg::status_t status,
    output lzsstsd_pkg::cmd_t    cmd
);

    import lzsstsd_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Take a word only outside a copy and when the result slot can be filled
    always_comb
    begin
        in_ready = !(state_reg inside {ST_COPY_RD, ST_COPY_WR}) && status.out_free;
    end

    assign accept = in_valid && in_ready;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        if (accept && stream_start)
        begin
            cmd.start  = 1'b1;
            state_next = ST_SIZE_LO;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    // drop stray words
                end
                ST_SIZE_LO:
                begin
                    if (accept)
                    begin
                        cmd.size_lo = 1'b1;
                        state_next  = ST_TOKEN;
                    end
                end
                ST_TOKEN:
                begin
                    if (accept)
                    begin
                        if (status.desc_empty)
                        begin
                            cmd.desc_load = 1'b1;
                        end
                        else
                        begin
                            cmd.desc_shift = 1'b1;
                            if (!status.desc_bit)
                            begin
                                cmd.emit_literal = 1'b1;
                            end
                            else if (status.is_term)
                            begin
                                cmd.emit_term = 1'b1;
                                state_next    = ST_IDLE;
                            end
                            else if (status.is_packed)
                            begin
                                cmd.lit_load = 1'b1;
                                state_next   = ST_LITERALS;
                            end
                            else if (status.is_short)
                            begin
                                if (status.dist_bad_short)
                                begin
                                    cmd.emit_derr = 1'b1;
                                end
                                else
                                begin
                                    cmd.match_load = 1'b1;
                                    state_next     = ST_COPY_RD;
                                end
                            end
                            else
                            begin
                                cmd.long_load = 1'b1;
                                state_next    = ST_LONG_LOW;
                            end
                        end
                    end
                end
                ST_LITERALS:
                begin
                    if (accept)
                    begin
                        cmd.emit_literal = 1'b1;
                        cmd.lit_dec      = 1'b1;
                        if (status.lit_last)
                        begin
                            state_next = ST_TOKEN;
                        end
                    end
                end
                ST_LONG_LOW:
                begin
                    if (accept)
                    begin
                        if (status.dist_bad_long)
                        begin
                            cmd.emit_derr = 1'b1;
                            state_next    = ST_TOKEN;
                        end
                        else
                        begin
                            cmd.match_load = 1'b1;
                            cmd.match_long = 1'b1;
                            state_next     = ST_COPY_RD;
                        end
                    end
                end
                ST_COPY_RD:
                begin
                    cmd.copy_read = 1'b1;
                    state_next    = ST_COPY_WR;
                end
                ST_COPY_WR:
                begin
                    // Hold the read byte until the result slot frees
                    if (status.out_free)
                    begin
                        cmd.copy_write = 1'b1;
                        state_next     = status.copy_last ? ST_TOKEN : ST_COPY_RD;
                    end
                end
                default:
                begin
                    state_next = ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/core/lzsstsd_dpath.sv =====
module lzsstsd_dpath #(
    parameter int WINDOW_DEPTH = lzsstsd_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [7:0]           in_byte,
    input  lzsstsd_pkg::cmd_t    cmd,
    output lzsstsd_pkg::status_t status,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           data_byte,
    output logic                 run_last,
    output logic                 end_of_stream,
    output logic                 size_mismatch,
    output logic                 distance_error
);

    import lzsstsd_pkg::*;

    localparam int AW = $clog2(WINDOW_DEPTH);

    logic [SIZE_W-1:0]  expected_reg, expected_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [AW-1:0]      wp_reg, wp_next;
    logic [7:0]         desc_reg, desc_next;
    logic [3:0]         desc_left_reg, desc_left_next;
    logic [LIT_W-1:0]   lit_reg, lit_next;
    logic [7:0]         high_reg, high_next;
    logic [DIST_W-1:0]  dist_reg, dist_next;
    logic [LEN_W-1:0]   len_reg, len_next;

    logic               out_valid_reg, out_valid_next;
    logic [7:0]         data_reg, data_next;
    logic               last_reg, last_next;
    logic               eos_reg, eos_next;
    logic               mism_reg, mism_next;
    logic               derr_reg, derr_next;

    logic [DIST_W-1:0]  dist_short;
    logic [DIST_W-1:0]  dist_long;
    logic [AW:0]        wp_ext;
    logic [AW:0]        dist_ext;
    logic [AW:0]        src_wide;
    logic [AW-1:0]      src_addr;
    logic [AW-1:0]      wp_inc;
    logic [COUNT_W-1:0] count_inc;
    logic               ram_we;
    logic [7:0]         ram_wdata;
    logic [7:0]         ram_q;
    logic               store;

    // Decode the incoming word
    assign dist_short = {{(DIST_W-4){1'b0}}, in_byte[3:0]};
    assign dist_long  = {high_reg[6:5], in_byte};

    always_comb
    begin
        status.out_free       = !out_valid_reg || out_ready;
        status.desc_empty     = (desc_left_reg == 4'd0);
        status.desc_bit       = desc_reg[0];
        status.lit_last       = (lit_reg == LIT_W'(1));
        status.is_term        = (in_byte == TERM_CODE);
        status.is_packed      = (in_byte[7:6] == 2'b11);
        status.is_short       = (in_byte[7:6] == 2'b10);
        status.dist_bad_short = (dist_short == '0)
                                || ({{(COUNT_W-DIST_W){1'b0}}, dist_short} > count_reg);
        status.dist_bad_long  = (dist_long == '0)
                                || ({{(COUNT_W-DIST_W){1'b0}}, dist_long} > count_reg);
        status.copy_last      = (len_reg == LEN_W'(1));
    end

    // Source address: write pointer minus distance, modulo window depth
    assign wp_ext   = {1'b0, wp_reg};
    assign dist_ext = {{(AW+1-DIST_W){1'b0}}, dist_reg};
    assign src_wide = (wp_ext >= dist_ext) ? (wp_ext - dist_ext)
                                           : (wp_ext + (AW+1)'(WINDOW_DEPTH) - dist_ext);
    assign src_addr = src_wide[AW-1:0];

    assign wp_inc    = (wp_reg == AW'(WINDOW_DEPTH - 1)) ? '0 : (wp_reg + 1'b1);
    assign count_inc = (count_reg == COUNT_MAX) ? count_reg : (count_reg + 1'b1);

    assign store     = cmd.emit_literal || cmd.copy_write;
    assign ram_we    = store;
    assign ram_wdata = cmd.copy_write ? ram_q : in_byte;

    lzsstsd_ram #(
        .WIDTH (8),
        .DEPTH (WINDOW_DEPTH)
    ) u_window (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wp_reg),
        .wdata (ram_wdata),
        .re    (cmd.copy_read),
        .raddr (src_addr),
        .rdata (ram_q)
    );

    // Stream state next values
    always_comb
    begin
        expected_next  = expected_reg;
        count_next     = count_reg;
        wp_next        = wp_reg;
        desc_next      = desc_reg;
        desc_left_next = desc_left_reg;
        lit_next       = lit_reg;
        high_next      = high_reg;
        dist_next      = dist_reg;
        len_next       = len_reg;

        if (cmd.start)
        begin
            expected_next  = {in_byte, 8'h00};
            count_next     = '0;
            wp_next        = '0;
            desc_next      = '0;
            desc_left_next = '0;
            lit_next       = '0;
            high_next      = '0;
        end
        if (cmd.size_lo)
        begin
            expected_next = {expected_reg[15:8], in_byte};
        end
        if (cmd.desc_load)
        begin
            desc_next      = in_byte;
            desc_left_next = 4'd8;
        end
        if (cmd.desc_shift)
        begin
            desc_next      = {1'b0, desc_reg[7:1]};
            desc_left_next = desc_left_reg - 1'b1;
        end
        if (cmd.lit_load)
        begin
            lit_next = {1'b0, in_byte[5:0]} + LIT_BIAS;
        end
        if (cmd.lit_dec)
        begin
            lit_next = lit_reg - 1'b1;
        end
        if (cmd.long_load)
        begin
            high_next = in_byte;
        end
        if (cmd.match_load)
        begin
            if (cmd.match_long)
            begin
                dist_next = dist_long;
                len_next  = {1'b0, high_reg[4:0]} + LONG_BIAS;
            end
            else
            begin
                dist_next = dist_short;
                len_next  = {4'b0000, in_byte[5:4]} + SHORT_BIAS;
            end
        end
        if (cmd.copy_write)
        begin
            len_next = len_reg - 1'b1;
        end
        if (store)
        begin
            wp_next    = wp_inc;
            count_next = count_inc;
        end
    end

    // Result register: load on emit, clear once taken
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        data_next      = data_reg;
        last_next      = last_reg;
        eos_next       = eos_reg;
        mism_next      = mism_reg;
        derr_next      = derr_reg;
        if (store || cmd.emit_term || cmd.emit_derr)
        begin
            out_valid_next = 1'b1;
            data_next      = '0;
            last_next      = 1'b1;
            eos_next       = 1'b0;
            mism_next      = 1'b0;
            derr_next      = 1'b0;
            if (cmd.emit_literal)
            begin
                data_next = in_byte;
            end
            if (cmd.copy_write)
            begin
                data_next = ram_q;
                last_next = status.copy_last;
            end
            if (cmd.emit_term)
            begin
                eos_next  = 1'b1;
                mism_next = ({1'b0, expected_reg} != count_reg);
            end
            if (cmd.emit_derr)
            begin
                derr_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_reg  <= '0;
            count_reg     <= '0;
            wp_reg        <= '0;
            desc_reg      <= '0;
            desc_left_reg <= '0;
            lit_reg       <= '0;
            high_reg      <= '0;
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            expected_reg  <= expected_next;
            count_reg     <= count_next;
            wp_reg        <= wp_next;
            desc_reg      <= desc_next;
            desc_left_reg <= desc_left_next;
            lit_reg       <= lit_next;
            high_reg      <= high_next;
            len_reg       <= len_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        dist_reg <= dist_next;
        data_reg <= data_next;
        last_reg <= last_next;
        eos_reg  <= eos_next;
        mism_reg <= mism_next;
        derr_reg <= derr_next;
    end

    assign out_valid      = out_valid_reg;
    assign data_byte      = data_reg;
    assign run_last       = last_reg;
    assign end_of_stream  = eos_reg;
    assign size_mismatch  = mism_reg;
    assign distance_error = derr_reg;

endmodule

// ===== rtl/core/lzss_token_stream_decompressor.sv =====
// LZSS token stream decompressor.
// Input channel (in_valid/in_ready): one compressed byte per word, with
// stream_start marking the high size byte that opens a stream.
// Output channel (out_valid/out_ready): one decompressed byte or status word
// per word; run_last marks the last word caused by an input byte.
// A literal byte shows at the output on the cycle after it is taken.
// A match copies each byte with a window read, then a write and emit, and
// holds the input until the copy ends; the registered read of the history
// memory, which must see the byte written just before it when the distance
// is one, is why the read and the write are separate states.
// A match with a bad distance gives one error word and copies nothing.
// One output register parts the channels: a word is taken while the previous
// result waits, as long as the receiver frees the register in that cycle.
// When the receiver stalls, the copy and the input hold until out_ready rises.
// Reset clears the decoder to idle; bytes without stream_start are dropped
// until a stream opens. The history memory needs no clearing pass.
module lzss_token_stream_decompressor #(
    parameter int WINDOW_DEPTH = lzsstsd_pkg::WINDOW_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       stream_start,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] data_byte,
    output logic       run_last,
    output logic       end_of_stream,
    output logic       size_mismatch,
    output logic       distance_error
);

    import lzsstsd_pkg::*;

    cmd_t    cmd;
    status_t status;

    lzsstsd_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .stream_start (stream_start),
        .in_ready     (in_ready),
        .status       (status),
        .cmd          (cmd)
    );

    lzsstsd_dpath #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_byte        (in_byte),
        .cmd            (cmd),
        .status         (status),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .data_byte      (data_byte),
        .run_last       (run_last),
        .end_of_stream  (end_of_stream),
        .size_mismatch  (size_mismatch),
        .distance_error (distance_error)
    );

endmodule

// ===== rtl/core/lzsstsd_chk.sv =====
module lzsstsd_chk (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] data_byte,
    input logic       run_last,
    input logic       end_of_stream,
    input logic       size_mismatch,
    input logic       distance_error
);

    // Terminator and distance error never share a word
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(end_of_stream && distance_error))
    else $error("terminator and distance error in one word");

    // Size mismatch only on the terminator word
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && size_mismatch) |-> end_of_stream)
    else $error("size mismatch outside terminator word");

    // Status words carry a zero byte and close their run
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (end_of_stream || distance_error)) |-> (data_byte == 8'h00 && run_last))
    else $error("status word with data or open run");

    // Stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(data_byte) && $stable(run_last)))
    else $error("stalled result changed");

endmodule

bind lzss_token_stream_decompressor lzsstsd_chk u_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .data_byte      (data_byte),
    .run_last       (run_last),
    .end_of_stream  (end_of_stream),
    .size_mismatch  (size_mismatch),
    .distance_error (distance_error)
);
